// ----- hw/rtl/lphm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared codes and constants for the linear probing hash map.
// ----------------------------------------------------------------------------
package lphm_pkg;

    localparam int USED_W  = 9;
    localparam int LIMIT_W = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd192;

    localparam logic [1:0] OP_GET = 2'd0;
    localparam logic [1:0] OP_SET = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_ABSENT = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;

    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_USED  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    localparam logic [31:0] MIX_C1 = 32'h7feb352d;
    localparam logic [31:0] MIX_C2 = 32'h846ca68b;

endpackage

// ----- hw/rtl/lphm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_req_if / lphm_rsp_if
// Valid/ready channels for map requests and results.
// ----------------------------------------------------------------------------
interface lphm_req_if #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            operation;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output operation, output key, output value,
                     input ready);
    modport sink   (input valid, input operation, input key, input value,
                     output ready);
endinterface

interface lphm_rsp_if #(
    parameter int VALUE_BITS = 32
) ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] read_value;
    logic                  was_new;

    modport source (output valid, output status, output read_value,
                     output was_new, input ready);
    modport sink   (input valid, input status, input read_value,
                     input was_new, output ready);
endinterface

// ----- hw/rtl/linear_probe_hash_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// Open addressing key/value map, linear probing with tombstones.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  i_req    in   valid/ready         operation, key, value
//  o_rsp    out  valid/ready         status, read_value, was_new
//  i_cfg    in   i_cfg_we (no wait)  i_cfg_wdata = load_limit
//
//  Hash runs on the shared multiplier through MUL1, MIX1, MUL2 and MIX2 (then
//  MUL3, MUL4 and RED when CAPACITY is not a power of two: reciprocal multiply
//  and correction), then EVAL probes one slot per step on the slot memory read
//  port, and DONE hands over the result. Op code 3 goes straight to DONE.
//  After reset a clearing pass marks every slot empty; i_req.ready stays low
//  meanwhile. A stalled result sits in the output register while the next
//  beat is taken and hashed.
// ----------------------------------------------------------------------------
module linear_probe_hash_map #(
    parameter int CAPACITY   = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lphm_pkg::LIMIT_W-1:0]    i_cfg_wdata,
    lphm_req_if.sink                        i_req,
    lphm_rsp_if.source                      o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam bit POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / CAPACITY);
    localparam logic [31:0] CAP32 = 32'(CAPACITY);
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL1 = 4'd1;
    localparam logic [3:0] ST_MIX1 = 4'd2;
    localparam logic [3:0] ST_MUL2 = 4'd3;
    localparam logic [3:0] ST_MIX2 = 4'd4;
    localparam logic [3:0] ST_MUL3 = 4'd5;
    localparam logic [3:0] ST_MUL4 = 4'd6;
    localparam logic [3:0] ST_RED  = 4'd7;
    localparam logic [3:0] ST_EVAL = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    typedef struct packed {
        logic [1:0]            st;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] val;
    } t_row;

    t_row mem [CAPACITY];

    logic [3:0]                    r_state, n_state;
    logic [1:0]                    r_op;
    logic [KEY_BITS-1:0]           r_key;
    logic [VALUE_BITS-1:0]         r_val;
    logic [31:0]                   r_h, n_h;
    logic [AW-1:0]                 r_at, n_at;
    logic [AW-1:0]                 r_n;
    logic                          r_tomb_seen;
    logic [AW-1:0]                 r_tomb_at;
    logic [lphm_pkg::USED_W-1:0]   r_used;
    logic [lphm_pkg::LIMIT_W-1:0]  r_limit;
    logic                          r_clr_busy;
    logic [AW-1:0]                 r_clr_addr;
    t_row                          r_rd;
    logic [1:0]                    r_res_status;
    logic [VALUE_BITS-1:0]         r_res_rdv;
    logic                          r_res_new;
    logic                          r_rsp_valid;
    logic [1:0]                    r_rsp_status;
    logic [VALUE_BITS-1:0]         r_rsp_rdv;
    logic                          r_rsp_new;

    logic [31:0]   mul_a, mul_b;
    logic [63:0]   mul_p;
    logic [63:0]   key_ext;
    logic [31:0]   fold, p1, h1, h2, red0, red1;
    logic [AW-1:0] at_next, rd_addr;
    logic          accept, rsp_load;
    logic          we;
    logic [AW-1:0] waddr;
    t_row          wrow;

    logic          is_hit, is_tomb, is_used, is_vacant, is_last, finish;
    logic          tomb_seen_c, have_slot, fresh, over_limit;
    logic [AW-1:0] tomb_at_c, slot_at;
    logic [1:0]    f_status;
    logic [VALUE_BITS-1:0] f_rdv;
    logic          f_new, f_we, f_inc;
    logic [AW-1:0] f_waddr;
    t_row          f_wrow;

    lphm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign accept  = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE) && !r_clr_busy;

    assign key_ext = 64'(i_req.key);
    assign fold    = key_ext[31:0] ^ key_ext[63:32];
    assign p1      = mul_p[31:0];
    assign h1      = p1 ^ (p1 >> 15);
    assign h2      = p1 ^ (p1 >> 16);
    assign red0    = r_h - mul_p[31:0];
    assign red1    = (red0 >= CAP32) ? (red0 - CAP32) : red0;
    assign at_next = (r_at == LAST) ? '0 : r_at + AW'(1);

    always_comb begin
        mul_a = r_h;
        mul_b = lphm_pkg::MIX_C1;
        unique case (r_state)
            ST_MUL2: mul_b = lphm_pkg::MIX_C2;
            ST_MUL3: mul_b = RECIP;
            ST_MUL4: begin
                mul_a = mul_p[63:32];
                mul_b = CAP32;
            end
            default: mul_b = lphm_pkg::MIX_C1;
        endcase
    end

    // probe decision on the slot read this cycle
    always_comb begin
        is_used     = r_rd.st == lphm_pkg::SLOT_USED;
        is_tomb     = r_rd.st == lphm_pkg::SLOT_TOMB;
        is_vacant   = !is_used && !is_tomb;
        is_hit      = is_used && (r_rd.key == r_key);
        is_last     = r_n == LAST;
        finish      = is_hit || is_vacant || is_last;
        tomb_seen_c = r_tomb_seen || is_tomb;
        tomb_at_c   = r_tomb_seen ? r_tomb_at : r_at;
        have_slot   = is_vacant || tomb_seen_c;
        slot_at     = tomb_seen_c ? tomb_at_c : r_at;
        fresh       = !tomb_seen_c;
        over_limit  = ({1'b0, r_used} + 10'd1) > {2'b00, r_limit};

        f_status = lphm_pkg::STAT_ABSENT;
        f_rdv    = '0;
        f_new    = 1'b0;
        f_we     = 1'b0;
        f_inc    = 1'b0;
        f_waddr  = r_at;
        f_wrow   = '{st: lphm_pkg::SLOT_USED, key: r_key, val: r_val};
        unique case (r_op)
            lphm_pkg::OP_GET: begin
                if (is_hit) begin
                    f_status = lphm_pkg::STAT_OK;
                    f_rdv    = r_rd.val;
                end
            end
            lphm_pkg::OP_DEL: begin
                if (is_hit) begin
                    f_status = lphm_pkg::STAT_OK;
                    f_we     = 1'b1;
                    f_wrow   = '{st: lphm_pkg::SLOT_TOMB, key: r_rd.key, val: r_rd.val};
                end
            end
            lphm_pkg::OP_SET: begin
                priority if (is_hit) begin
                    f_status = lphm_pkg::STAT_OK;
                    f_we     = 1'b1;
                end else if (!have_slot || (fresh && over_limit)) begin
                    f_status = lphm_pkg::STAT_FULL;
                end else begin
                    f_status = lphm_pkg::STAT_OK;
                    f_new    = 1'b1;
                    f_we     = 1'b1;
                    f_inc    = fresh;
                    f_waddr  = slot_at;
                end
            end
            default: f_status = lphm_pkg::STAT_ABSENT;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_at    = r_at;
        rd_addr = at_next;
        unique case (r_state)
            ST_IDLE: begin
                n_h = fold ^ (fold >> 16);
                if (accept) begin
                    n_state = (i_req.operation == lphm_pkg::OP_GET ||
                               i_req.operation == lphm_pkg::OP_SET ||
                               i_req.operation == lphm_pkg::OP_DEL) ? ST_MUL1 : ST_DONE;
                end
            end
            ST_MUL1: n_state = ST_MIX1;
            ST_MIX1: begin
                n_h     = h1;
                n_state = ST_MUL2;
            end
            ST_MUL2: n_state = ST_MIX2;
            ST_MIX2: begin
                n_h = h2;
                if (POW2) begin
                    rd_addr = h2[AW-1:0];
                    n_at    = h2[AW-1:0];
                    n_state = ST_EVAL;
                end else begin
                    n_state = ST_MUL3;
                end
            end
            ST_MUL3: n_state = ST_MUL4;
            ST_MUL4: n_state = ST_RED;
            ST_RED: begin
                rd_addr = red1[AW-1:0];
                n_at    = red1[AW-1:0];
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_at = at_next;
                if (finish) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (rsp_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign rsp_load = (r_state == ST_DONE) && (!r_rsp_valid || o_rsp.ready);

    always_comb begin
        if (r_clr_busy) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wrow  = '{st: lphm_pkg::SLOT_EMPTY, key: '0, val: '0};
        end else begin
            we    = (r_state == ST_EVAL) && finish && f_we;
            waddr = f_waddr;
            wrow  = f_wrow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wrow;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_limit     <= lphm_pkg::LIMIT_RESET;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if ((r_state == ST_EVAL) && finish && f_inc) begin
                r_used <= r_used + lphm_pkg::USED_W'(1);
            end
            r_rsp_valid <= rsp_load || (r_rsp_valid && !o_rsp.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_h  <= n_h;
        r_at <= n_at;
        if (accept) begin
            r_op         <= i_req.operation;
            r_key        <= i_req.key;
            r_val        <= i_req.value;
            r_res_status <= lphm_pkg::STAT_ABSENT;
            r_res_rdv    <= '0;
            r_res_new    <= 1'b0;
        end
        if (r_state != ST_EVAL) begin
            r_n         <= '0;
            r_tomb_seen <= 1'b0;
        end else begin
            r_n         <= r_n + AW'(1);
            r_tomb_seen <= tomb_seen_c;
            r_tomb_at   <= tomb_at_c;
            if (finish) begin
                r_res_status <= f_status;
                r_res_rdv    <= f_rdv;
                r_res_new    <= f_new;
            end
        end
        if (rsp_load) begin
            r_rsp_status <= r_res_status;
            r_rsp_rdv    <= r_res_rdv;
            r_rsp_new    <= r_res_new;
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.status     = r_rsp_status;
    assign o_rsp.read_value = r_rsp_rdv;
    assign o_rsp.was_new    = r_rsp_new;

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_used != $past(r_used)) |->
            (r_used == $past(r_used) + lphm_pkg::USED_W'(1)) &&
            ($past(r_op) == lphm_pkg::OP_SET) && ($past(r_state) == ST_EVAL))
        else $error("used count moved outside a fresh set");

    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> r_clr_busy || (r_state == ST_EVAL))
        else $error("slot write outside probe or clearing");

    a_clr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (r_state == ST_IDLE) && !r_rsp_valid)
        else $error("item in flight during clearing pass");

    a_full_not_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == lphm_pkg::STAT_FULL) |-> !o_rsp.was_new)
        else $error("refused set flagged as new");

endmodule

// ----- hw/rtl/lphm_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_mul
// Shared 32x32 multiplier with registered 64-bit product.
// ----------------------------------------------------------------------------
module lphm_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for linear_probe_hash_map. Request beats are mirrored
// into a software copy of the slot table, which predicts status, read value
// and was_new for every request. Results are compared in order. Stimulus
// runs a directed pass over probe wrap, tombstone reuse and load refusal,
// then random get/set/delete and op code 3 traffic over key pools at rising
// load limits, with random stalls on both channels.
// ----------------------------------------------------------------------------
localparam int MAP_SLOTS = 256;
localparam logic [1:0] OP_UNUSED = 2'd3;

typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic        was_new;
} t_map_result;

class map_tracker;
    logic [31:0]                  slot_key   [MAP_SLOTS];
    logic [31:0]                  slot_val   [MAP_SLOTS];
    logic [1:0]                   slot_state [MAP_SLOTS];
    int unsigned                  used_slots;
    logic [lphm_pkg::LIMIT_W-1:0] load_limit;
    t_map_result                  awaited [$];
    int unsigned                  mismatches;

    function new();
        foreach (slot_state[i]) begin
            slot_state[i] = lphm_pkg::SLOT_EMPTY;
            slot_key[i]   = '0;
            slot_val[i]   = '0;
        end
        used_slots = 0;
        load_limit = lphm_pkg::LIMIT_RESET;
        mismatches = 0;
    endfunction

    function int unsigned home_slot(logic [31:0] key);
        logic [31:0] h;
        h = key;
        h = h ^ (h >> 16);
        h = h * lphm_pkg::MIX_C1;
        h = h ^ (h >> 15);
        h = h * lphm_pkg::MIX_C2;
        h = h ^ (h >> 16);
        return h % MAP_SLOTS;
    endfunction

    function logic [31:0] key_for_slot(int unsigned slot);
        logic [31:0] k;
        do k = $urandom; while (home_slot(k) != slot);
        return k;
    endfunction

    function int unsigned pending();
        return awaited.size();
    endfunction

    function void note_request(logic [1:0] op, logic [31:0] key, logic [31:0] value);
        t_map_result res;
        int unsigned at, n, tomb_at, hit_at, free_at;
        bit          tomb_seen, hit, have_free, fresh;
        res.status     = lphm_pkg::STAT_ABSENT;
        res.read_value = '0;
        res.was_new    = 1'b0;
        tomb_seen = 0;
        hit       = 0;
        have_free = 0;
        fresh     = 0;
        tomb_at   = 0;
        hit_at    = 0;
        free_at   = 0;
        if (op != OP_UNUSED) begin
            at = home_slot(key);
            for (n = 0; n < MAP_SLOTS && !hit && !have_free; n++) begin
                if (slot_state[at] == lphm_pkg::SLOT_USED) begin
                    if (slot_key[at] == key) begin
                        hit    = 1;
                        hit_at = at;
                    end
                end else if (slot_state[at] == lphm_pkg::SLOT_TOMB) begin
                    if (!tomb_seen) begin
                        tomb_seen = 1;
                        tomb_at   = at;
                    end
                end else begin
                    have_free = 1;
                    free_at   = tomb_seen ? tomb_at : at;
                    fresh     = !tomb_seen;
                end
                at = (at + 1) % MAP_SLOTS;
            end
            if (!hit && !have_free && tomb_seen) begin
                have_free = 1;
                free_at   = tomb_at;
            end
            case (op)
                lphm_pkg::OP_GET: begin
                    if (hit) begin
                        res.status     = lphm_pkg::STAT_OK;
                        res.read_value = slot_val[hit_at];
                    end
                end
                lphm_pkg::OP_DEL: begin
                    if (hit) begin
                        slot_state[hit_at] = lphm_pkg::SLOT_TOMB;
                        res.status         = lphm_pkg::STAT_OK;
                    end
                end
                default: begin
                    if (hit) begin
                        slot_val[hit_at] = value;
                        res.status       = lphm_pkg::STAT_OK;
                    end else if (!have_free || (fresh && used_slots + 1 > load_limit)) begin
                        res.status = lphm_pkg::STAT_FULL;
                    end else begin
                        if (fresh)
                            used_slots++;
                        slot_key[free_at]   = key;
                        slot_val[free_at]   = value;
                        slot_state[free_at] = lphm_pkg::SLOT_USED;
                        res.status          = lphm_pkg::STAT_OK;
                        res.was_new         = 1'b1;
                    end
                end
            endcase
        end
        awaited.push_back(res);
    endfunction

    function void check_result(logic [1:0] status, logic [31:0] read_value, logic was_new);
        t_map_result want;
        if (awaited.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %h",
                     $time, status);
            $display("%0t: actual read_value %h was_new %b", $time, read_value, was_new);
            mismatches++;
            return;
        end
        want = awaited.pop_front();
        if (status !== want.status) begin
            $display("%0t: status expected %h actual %h", $time, want.status, status);
            mismatches++;
        end
        if (read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h",
                     $time, want.read_value, read_value);
            mismatches++;
        end
        if (was_new !== want.was_new) begin
            $display("%0t: was_new expected %b actual %b", $time, want.was_new, was_new);
            mismatches++;
        end
    endfunction
endclass

module tb;

    localparam int QUIET_LIMIT = 4000;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_we;
    logic [lphm_pkg::LIMIT_W-1:0] cfg_wdata;
    bit                           steady;

    map_tracker tracker = new();

    lphm_req_if #(.KEY_BITS(32), .VALUE_BITS(32)) req_bus ();
    lphm_rsp_if #(.VALUE_BITS(32)) rsp_bus ();

    linear_probe_hash_map #(
        .CAPACITY   (MAP_SLOTS),
        .KEY_BITS   (32),
        .VALUE_BITS (32)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_bus.sink),
        .o_rsp       (rsp_bus.source)
    );

    always #5 clk = ~clk;

    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 27);
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
            tracker.check_result(rsp_bus.status, rsp_bus.read_value, rsp_bus.was_new);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb failed");
        $finish;
    end

    task automatic send_beat(logic [1:0] op, logic [31:0] key, logic [31:0] value);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 27) begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.operation <= op;
        req_bus.key       <= key;
        req_bus.value     <= value;
        do @(posedge clk); while (!req_bus.ready);
        tracker.note_request(op, key, value);
    endtask

    task automatic settle();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(logic [lphm_pkg::LIMIT_W-1:0] limit);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        tracker.load_limit = limit;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(logic [lphm_pkg::LIMIT_W-1:0] limit, int items, int pool_len,
                                int steady_len);
        logic [31:0] pool [$];
        logic [31:0] cluster [$];
        int unsigned base;
        int          i, r;
        logic [1:0]  op;
        logic [31:0] key;
        write_limit(limit);
        base = $urandom_range(0, MAP_SLOTS - 1);
        repeat (pool_len) pool.push_back($urandom);
        repeat (16) cluster.push_back(tracker.key_for_slot(base));
        steady = (steady_len > 0);
        for (i = 0; i < items; i++) begin
            if (i == steady_len)
                steady = 1'b0;
            if (i == items / 2)
                settle();
            r = $urandom_range(0, 99);
            if (r < 40)
                op = lphm_pkg::OP_SET;
            else if (r < 70)
                op = lphm_pkg::OP_GET;
            else if (r < 95)
                op = lphm_pkg::OP_DEL;
            else
                op = OP_UNUSED;
            r = $urandom_range(0, 99);
            if (r < 70)
                key = pool[$urandom_range(0, pool_len - 1)];
            else if (r < 85)
                key = cluster[$urandom_range(0, 15)];
            else
                key = $urandom;
            send_beat(op, key, $urandom);
        end
        steady = 1'b0;
    endtask

    initial begin : stimulus
        logic [31:0] key_a, key_b, key_c;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        steady            = 1'b0;
        req_bus.valid     = 1'b0;
        req_bus.operation = lphm_pkg::OP_GET;
        req_bus.key       = '0;
        req_bus.value     = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // three keys homed on the last slot: chain wraps to slots 0 and 1
        key_a = tracker.key_for_slot(MAP_SLOTS - 1);
        do key_b = tracker.key_for_slot(MAP_SLOTS - 1); while (key_b == key_a);
        do key_c = tracker.key_for_slot(MAP_SLOTS - 1); while (key_c == key_a || key_c == key_b);

        send_beat(lphm_pkg::OP_GET, key_a, 32'h0);
        send_beat(lphm_pkg::OP_DEL, key_a, 32'h0);
        send_beat(lphm_pkg::OP_SET, key_a, 32'h0);
        send_beat(lphm_pkg::OP_SET, key_b, 32'hffff_ffff);
        send_beat(lphm_pkg::OP_SET, key_c, 32'h1234_5678);
        send_beat(lphm_pkg::OP_GET, key_c, 32'hffff_ffff);
        send_beat(lphm_pkg::OP_SET, key_a, 32'hffff_ffff);
        send_beat(lphm_pkg::OP_GET, key_a, 32'h0);
        send_beat(lphm_pkg::OP_DEL, key_b, 32'h0);
        send_beat(lphm_pkg::OP_GET, key_c, 32'h0);
        send_beat(lphm_pkg::OP_GET, key_b, 32'h0);
        send_beat(lphm_pkg::OP_SET, key_b, 32'h0000_0005);
        send_beat(lphm_pkg::OP_DEL, key_b, 32'h0);
        send_beat(lphm_pkg::OP_DEL, key_b, 32'h0);
        send_beat(lphm_pkg::OP_SET, 32'h0, 32'h0);
        send_beat(lphm_pkg::OP_GET, 32'h0, 32'hffff_ffff);
        send_beat(lphm_pkg::OP_SET, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(lphm_pkg::OP_GET, 32'hffff_ffff, 32'h0);
        send_beat(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(lphm_pkg::OP_DEL, 32'h0, 32'h0);
        send_beat(lphm_pkg::OP_DEL, 32'hffff_ffff, 32'h0);

        // zero limit: fresh slots refused, tombstones still reusable
        write_limit(8'd0);
        send_beat(lphm_pkg::OP_SET, $urandom, $urandom);
        send_beat(lphm_pkg::OP_SET, 32'h0, 32'hffff_ffff);
        send_beat(lphm_pkg::OP_SET, key_b, 32'h0);

        write_limit(8'd1);
        send_beat(lphm_pkg::OP_SET, $urandom, $urandom);
        send_beat(lphm_pkg::OP_GET, 32'h0, 32'h0);

        random_phase(8'd60, 500, 40, 0);
        random_phase(8'd130, 600, 100, 200);
        random_phase(8'd255, 700, 300, 0);

        settle();
        repeat (16) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
